@@ design/ptt_pkg.sv @@
// Shared types and constants for the periodic timer table.
// Opcodes, result kinds, register indexes and fixed field widths.
// No dependencies.
package ptt_pkg;

  localparam int ID_W       = 4;
  localparam int REQ_W      = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [1:0] {
    OP_CREATE  = 2'd0,
    OP_DESTROY = 2'd1,
    OP_TICK    = 2'd2,
    OP_UPDATE  = 2'd3
  } ptt_op_e;

  typedef enum logic [1:0] {
    KIND_REPLY = 2'd0,
    KIND_FIRED = 2'd1,
    KIND_DONE  = 2'd2
  } ptt_kind_e;

  localparam logic [CFG_IDX_W-1:0] REG_TICK_SPAN = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_MIN_SPAN  = CFG_IDX_W'(1);

endpackage

@@ design/ptt_if.sv @@
// Valid/ready channel interfaces for command transactions and result transactions.
// Depends on ptt_pkg.
interface ptt_in_if;
  import ptt_pkg::*;

  logic              valid;
  logic              ready;
  ptt_op_e           opcode;
  logic [ID_W-1:0]   timer_id;
  logic [REQ_W-1:0]  span_value;
  logic [REQ_W-1:0]  elapsed;

  modport source (output valid, opcode, timer_id, span_value, elapsed, input ready);
  modport sink   (input valid, opcode, timer_id, span_value, elapsed, output ready);
endinterface

interface ptt_out_if;
  import ptt_pkg::*;

  logic            valid;
  logic            ready;
  ptt_kind_e       kind;
  logic [ID_W-1:0] fired_id;
  logic            status;
  logic            last;

  modport source (output valid, kind, fired_id, status, last, input ready);
  modport sink   (input valid, kind, fired_id, status, last, output ready);
endinterface

@@ design/ptt_ram.sv @@
// Simple dual-port synchronous RAM: one write port, one read port with registered data.
// No dependencies.
module ptt_ram #(
  parameter int  Depth = 16,
  parameter int  Width = 32,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

@@ design/ptt_seq.sv @@
// Command sequencer and slot walker: valid bits, span/remaining RAMs, result register.
// Depends on ptt_pkg, ptt_if and ptt_ram.
module ptt_seq #(
  parameter int TIMER_SLOTS = 16,
  parameter int SPAN_BITS   = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [SPAN_BITS-1:0] tick_span_i,
  input  logic [SPAN_BITS-1:0] min_span_i,
  ptt_in_if.sink               in_i,
  ptt_out_if.source            out_o
);
  import ptt_pkg::*;

  localparam int AddrW  = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
  localparam int CntW   = $clog2(TIMER_SLOTS + 1);
  localparam int CmpW   = (CntW > ID_W) ? CntW : ID_W;
  localparam int IdExtW = (AddrW > ID_W) ? AddrW : ID_W;
  localparam logic [CntW-1:0] LastCnt = CntW'(TIMER_SLOTS);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CMD   = 3'd1;
  localparam logic [2:0] S_CRWR  = 3'd2;
  localparam logic [2:0] S_REPLY = 3'd3;
  localparam logic [2:0] S_RD    = 3'd4;
  localparam logic [2:0] S_PROC  = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [2:0]             state_q, state_d;
  ptt_op_e                op_q;
  logic [ID_W-1:0]        id_q;
  logic [SPAN_BITS-1:0]   req_q, el_q;
  logic                   status_q, status_d;
  logic [SPAN_BITS-1:0]   span_q, span_d, lag_q, lag_d;
  logic [CntW-1:0]        idx_q, idx_d;
  logic [TIMER_SLOTS-1:0] valid_q, valid_d;

  logic                   out_valid_q;
  ptt_kind_e              out_kind_q, out_kind_d;
  logic [ID_W-1:0]        out_id_q, out_id_d;
  logic                   out_status_q, out_status_d;
  logic                   out_last_q, out_last_d;
  logic                   out_load;

  logic                   in_acc, out_free, in_range, slot_ok, walk_end, walk_valid;
  logic [IdExtW-1:0]      id_ext;
  logic [AddrW-1:0]       id_addr, walk_addr;

  logic                   span_we, rem_we, rd_en;
  logic [AddrW-1:0]       span_waddr, rem_waddr;
  logic [SPAN_BITS-1:0]   span_wdata, rem_wdata, span_rd, rem_rd;

  ptt_ram #(.Depth(TIMER_SLOTS), .Width(SPAN_BITS)) u_span_ram (
    .clk_i   (clk_i),
    .we_i    (span_we),
    .waddr_i (span_waddr),
    .wdata_i (span_wdata),
    .re_i    (rd_en),
    .raddr_i (walk_addr),
    .rdata_o (span_rd)
  );

  ptt_ram #(.Depth(TIMER_SLOTS), .Width(SPAN_BITS)) u_rem_ram (
    .clk_i   (clk_i),
    .we_i    (rem_we),
    .waddr_i (rem_waddr),
    .wdata_i (rem_wdata),
    .re_i    (rd_en),
    .raddr_i (walk_addr),
    .rdata_o (rem_rd)
  );

  assign in_i.ready = (state_q == S_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign out_free   = !out_valid_q || out_o.ready;

  assign id_ext     = IdExtW'(id_q);
  assign id_addr    = id_ext[AddrW-1:0];
  assign in_range   = CmpW'(id_q) < CmpW'(TIMER_SLOTS);
  assign slot_ok    = in_range && valid_q[id_addr];
  assign walk_addr  = idx_q[AddrW-1:0];
  assign walk_end   = (idx_q == LastCnt);
  assign walk_valid = !walk_end && valid_q[walk_addr];

  always_comb begin
    state_d      = state_q;
    idx_d        = idx_q;
    valid_d      = valid_q;
    status_d     = status_q;
    span_d       = span_q;
    lag_d        = lag_q;
    span_we      = 1'b0;
    span_waddr   = id_addr;
    span_wdata   = span_q;
    rem_we       = 1'b0;
    rem_waddr    = id_addr;
    rem_wdata    = span_q - lag_q;
    rd_en        = 1'b0;
    out_load     = 1'b0;
    out_kind_d   = KIND_REPLY;
    out_id_d     = id_q;
    out_status_d = status_q;
    out_last_d   = 1'b1;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          state_d = S_CMD;
        end
      end
      S_CMD: begin
        status_d = 1'b0;
        state_d  = S_REPLY;
        case (op_q)
          OP_CREATE: begin
            if (slot_ok) begin
              status_d = 1'b1;
            end else if (in_range) begin
              span_d  = (tick_span_i > req_q) ? tick_span_i : req_q;
              lag_d   = tick_span_i - ((el_q < tick_span_i) ? el_q : tick_span_i);
              state_d = S_CRWR;
            end
          end
          OP_DESTROY: begin
            if (in_range) begin
              valid_d[id_addr] = 1'b0;
            end
          end
          OP_UPDATE: begin
            if (slot_ok) begin
              span_we    = 1'b1;
              span_wdata = (min_span_i > req_q) ? min_span_i : req_q;
            end
          end
          OP_TICK: begin
            idx_d   = '0;
            state_d = S_RD;
          end
          default: begin
            state_d = S_REPLY;
          end
        endcase
      end
      S_CRWR: begin
        span_we          = 1'b1;
        rem_we           = 1'b1;
        valid_d[id_addr] = 1'b1;
        state_d          = S_REPLY;
      end
      S_REPLY: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      S_RD: begin
        if (walk_end) begin
          state_d = S_DONE;
        end else if (walk_valid) begin
          rd_en   = 1'b1;
          state_d = S_PROC;
        end else begin
          idx_d = idx_q + CntW'(1);
        end
      end
      S_PROC: begin
        rem_waddr = walk_addr;
        if (rem_rd >= tick_span_i) begin
          rem_we    = 1'b1;
          rem_wdata = rem_rd - tick_span_i;
          idx_d     = idx_q + CntW'(1);
          state_d   = S_RD;
        end else if (rem_rd != '0) begin
          rem_we    = 1'b1;
          rem_wdata = tick_span_i;
          idx_d     = idx_q + CntW'(1);
          state_d   = S_RD;
        end else if (out_free) begin
          rem_we       = 1'b1;
          rem_wdata    = span_rd;
          out_load     = 1'b1;
          out_kind_d   = KIND_FIRED;
          out_id_d     = ID_W'(idx_q);
          out_status_d = 1'b0;
          out_last_d   = 1'b0;
          idx_d        = idx_q + CntW'(1);
          state_d      = S_RD;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_load     = 1'b1;
          out_kind_d   = KIND_DONE;
          out_id_d     = '0;
          out_status_d = 1'b0;
          out_last_d   = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      idx_q       <= '0;
      valid_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      valid_q <= valid_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q  <= in_i.opcode;
      id_q  <= in_i.timer_id;
      req_q <= SPAN_BITS'(in_i.span_value);
      el_q  <= SPAN_BITS'(in_i.elapsed);
    end
    status_q <= status_d;
    span_q   <= span_d;
    lag_q    <= lag_d;
    if (out_load) begin
      out_kind_q   <= out_kind_d;
      out_id_q     <= out_id_d;
      out_status_q <= out_status_d;
      out_last_q   <= out_last_d;
    end
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.kind     = out_kind_q;
  assign out_o.fired_id = out_id_q;
  assign out_o.status   = out_status_q;
  assign out_o.last     = out_last_q;

`ifndef SYNTH
  a_accept_to_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> state_q == S_CMD)
    else $error("accepted transaction did not enter command decode");

  a_fired_in_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load && out_kind_d == KIND_FIRED |-> op_q == OP_TICK && !out_last_d)
    else $error("fired result outside a tick walk");

  a_walk_valid_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_PROC |-> ($past(rd_en) || $past(state_q) == S_PROC) && valid_q[walk_addr])
    else $error("slot update without read of a valid slot");

  a_walk_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q <= LastCnt)
    else $error("walk counter beyond slot count");
`endif

endmodule

@@ design/periodic_timer_table.sv @@
// Periodic timer table. Create, destroy, update: decoded in S_CMD (a fresh create then
// writes its slot in S_CRWR), reply registered in S_REPLY; one transaction at a time.
// Tick: walks all slots in order, reading the span and remaining RAMs for open slots,
// with a fired result per expiring slot and then a done marker.
// Reset clears all valid bits and sets tick_span and min_span to 1; no RAM clearing pass.
module periodic_timer_table #(
  parameter int TIMER_SLOTS = 16,
  parameter int SPAN_BITS   = 32
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [ptt_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [ptt_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  ptt_in_if.sink                           in_i,
  ptt_out_if.source                        out_o
);
  import ptt_pkg::*;

  logic [SPAN_BITS-1:0] tick_span_q, min_span_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_span_q <= SPAN_BITS'(1);
      min_span_q  <= SPAN_BITS'(1);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_TICK_SPAN: tick_span_q <= SPAN_BITS'(cfg_data_i);
        REG_MIN_SPAN:  min_span_q  <= SPAN_BITS'(cfg_data_i);
        default: begin
        end
      endcase
    end
  end

  ptt_seq #(.TIMER_SLOTS(TIMER_SLOTS), .SPAN_BITS(SPAN_BITS)) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tick_span_i (tick_span_q),
    .min_span_i  (min_span_q),
    .in_i        (in_i),
    .out_o       (out_o)
  );

endmodule

@@ tb/testbench.sv @@
// Self-checking bench for periodic_timer_table: directed table plus random command streams.
// Predicts replies, fired ids and tick done markers from its own copy of the slot table.
// Depends on ptt_pkg, ptt_in_if, ptt_out_if and periodic_timer_table.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import ptt_pkg::*;

  localparam int SLOTS      = 16;
  localparam int IDLE_LIMIT = 3000;
  localparam int LONG_HOLD  = 300;
  localparam int SETTLE     = 40;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = CFG_IDX_W'(3);

  typedef struct packed {
    ptt_op_e     op;
    logic [3:0]  id;
    logic [31:0] span;
    logic [31:0] el;
    logic        typed;
    ptt_kind_e   t_kind;
    logic        t_status;
  } cmd_t;

  typedef struct packed {
    ptt_kind_e  kind;
    logic [3:0] id;
    logic       status;
    logic       last;
  } res_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  ptt_in_if  cmd_if ();
  ptt_out_if res_if ();

  periodic_timer_table #(
    .TIMER_SLOTS(SLOTS),
    .SPAN_BITS  (32)
  ) dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .in_i      (cmd_if),
    .out_o     (res_if)
  );

  logic        slot_open   [SLOTS];
  logic [31:0] slot_period [SLOTS];
  logic [31:0] slot_count  [SLOTS];
  logic [31:0] tick_reg;
  logic [31:0] min_reg;

  res_t pending_results[$];
  cmd_t cmd_queue[$];
  cmd_t cmd_on_bus;
  cmd_t plan [21];

  int cmds_in_flight = 0;
  int errors         = 0;
  int gap_left       = 0;
  int burst_left     = 0;
  int hold_req       = 0;
  int hold_seen      = 0;
  int hold_left      = 0;
  int stall_mode     = 0;
  int mode_left      = 0;
  int idle_cycles    = 0;
  logic [7:0] stall_pat = 8'hA5;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  task automatic timer_table_step(input cmd_t c);
    res_t        found[$];
    logic [31:0] span;
    logic [31:0] lag;
    logic        status;
    status = 1'b0;
    if (c.op == OP_TICK) begin
      for (int i = 0; i < SLOTS; i++) begin
        if (slot_open[i]) begin
          if (slot_count[i] >= tick_reg) begin
            slot_count[i] = slot_count[i] - tick_reg;
          end else if (slot_count[i] != 32'd0) begin
            slot_count[i] = tick_reg;
          end else begin
            slot_count[i] = slot_period[i];
            found.push_back('{KIND_FIRED, 4'(i), 1'b0, 1'b0});
          end
        end
      end
      found.push_back('{KIND_DONE, 4'd0, 1'b0, 1'b1});
    end else begin
      if (c.op == OP_CREATE) begin
        if (slot_open[c.id]) begin
          status = 1'b1;
        end else begin
          span = (c.span > tick_reg) ? c.span : tick_reg;
          lag  = tick_reg - ((c.el < tick_reg) ? c.el : tick_reg);
          slot_open[c.id]   = 1'b1;
          slot_period[c.id] = span;
          slot_count[c.id]  = span - lag;
        end
      end else if (c.op == OP_DESTROY) begin
        slot_open[c.id] = 1'b0;
      end else if (slot_open[c.id]) begin
        slot_period[c.id] = (c.span > min_reg) ? c.span : min_reg;
      end
      found.push_back('{KIND_REPLY, c.id, status, 1'b1});
    end
    if (c.typed) begin
      pending_results.push_back('{c.t_kind, (c.t_kind == KIND_DONE) ? 4'd0 : c.id,
                                  c.t_status, 1'b1});
    end else begin
      foreach (found[k]) pending_results.push_back(found[k]);
    end
  endtask

  function automatic logic [3:0] pick_slot(input logic want_open);
    int start;
    start = $urandom_range(0, SLOTS - 1);
    for (int k = 0; k < SLOTS; k++) begin
      if (slot_open[(start + k) % SLOTS] == want_open) return 4'((start + k) % SLOTS);
    end
    return 4'(start);
  endfunction

  function automatic cmd_t make_random_cmd(input int unsigned span_cap,
                                           input int unsigned el_cap);
    cmd_t c;
    int   r;
    c = '0;
    r = $urandom_range(0, 99);
    if (r < 35) c.op = OP_CREATE;
    else if (r < 65) c.op = OP_TICK;
    else if (r < 80) c.op = OP_UPDATE;
    else c.op = OP_DESTROY;
    if ($urandom_range(0, 3) == 0) c.id = 4'($urandom_range(0, SLOTS - 1));
    else c.id = pick_slot(c.op != OP_CREATE);
    c.span   = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, span_cap);
    c.el     = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, el_cap);
    c.t_kind = KIND_REPLY;
    return c;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_if.valid      <= 1'b0;
      cmd_if.opcode     <= OP_CREATE;
      cmd_if.timer_id   <= '0;
      cmd_if.span_value <= '0;
      cmd_if.elapsed    <= '0;
    end else begin
      if (cmd_if.valid && cmd_if.ready) begin
        timer_table_step(cmd_on_bus);
        cmds_in_flight--;
      end
      if (!cmd_if.valid || cmd_if.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          cmd_if.valid <= 1'b0;
        end else if (cmd_queue.size() == 0) begin
          cmd_if.valid <= 1'b0;
        end else begin
          cmd_on_bus         = cmd_queue.pop_front();
          cmd_if.valid      <= 1'b1;
          cmd_if.opcode     <= cmd_on_bus.op;
          cmd_if.timer_id   <= cmd_on_bus.id;
          cmd_if.span_value <= cmd_on_bus.span;
          cmd_if.elapsed    <= cmd_on_bus.el;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 20);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 :
                         $urandom_range(1, ($urandom_range(0, 4) == 0) ? 25 : 5);
          end
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    res_t exp_res;
    logic rdy;
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        if (pending_results.size() == 0) begin
          errors++;
          $display("%0t: unexpected result: kind=%0d id=%0d status=%0d last=%0d", $time,
                   res_if.kind, res_if.fired_id, res_if.status, res_if.last);
        end else begin
          exp_res = pending_results.pop_front();
          if (res_if.kind !== exp_res.kind || res_if.fired_id !== exp_res.id ||
              res_if.status !== exp_res.status || res_if.last !== exp_res.last) begin
            errors++;
            $display("%0t: mismatch: expected %0d/%0d/%0d/%0d, actual %0d/%0d/%0d/%0d",
                     $time, exp_res.kind, exp_res.id, exp_res.status, exp_res.last,
                     res_if.kind, res_if.fired_id, res_if.status, res_if.last);
          end
        end
      end
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = LONG_HOLD;
      end
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left  = $urandom_range(8, 80);
        stall_pat  = 8'($urandom);
      end else begin
        mode_left--;
      end
      stall_pat = {stall_pat[0], stall_pat[7:1]};
      if (hold_left > 0) begin
        hold_left--;
        rdy = 1'b0;
      end else begin
        case (stall_mode)
          0: rdy = 1'b1;
          1: rdy = 1'($urandom_range(0, 1));
          2: rdy = stall_pat[0];
          default: rdy = ($urandom_range(0, 7) != 0);
        endcase
      end
      res_if.ready <= rdy;
    end
  end

  always @(posedge clk_i) begin
    if ((cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    if (idx == REG_TICK_SPAN) tick_reg = value;
    else if (idx == REG_MIN_SPAN) min_reg = value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic queue_random(input int count, input int unsigned span_cap,
                              input int unsigned el_cap);
    for (int n = 0; n < count; n++) begin
      cmd_queue.push_back(make_random_cmd(span_cap, el_cap));
      cmds_in_flight++;
    end
  endtask

  task automatic wait_drained();
    do @(negedge clk_i); while (cmds_in_flight != 0 || pending_results.size() != 0);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  initial begin
    rst_ni     <= 1'b0;
    cfg_we_i   <= 1'b0;
    cfg_idx_i  <= '0;
    cfg_data_i <= '0;
    tick_reg = 32'd1;
    min_reg  = 32'd1;
    foreach (slot_open[i]) begin
      slot_open[i]   = 1'b0;
      slot_period[i] = '0;
      slot_count[i]  = '0;
    end

    plan = '{
      '{OP_TICK,    4'd15, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, KIND_DONE,  1'b0},
      '{OP_CREATE,  4'd0,  32'h0000_0000, 32'h0000_0000, 1'b1, KIND_REPLY, 1'b0},
      '{OP_CREATE,  4'd0,  32'h0000_0005, 32'h0000_0000, 1'b1, KIND_REPLY, 1'b1},
      '{OP_CREATE,  4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, KIND_REPLY, 1'b0},
      '{OP_TICK,    4'd0,  32'h0000_0000, 32'h0000_0000, 1'b0, KIND_REPLY, 1'b0},
      '{OP_UPDATE,  4'd0,  32'h0000_0003, 32'h0000_0000, 1'b1, KIND_REPLY, 1'b0},
      '{OP_UPDATE,  4'd7,  32'h0000_0005, 32'h0000_0000, 1'b1, KIND_REPLY, 1'b0},
      '{OP_DESTROY, 4'd9,  32'h0000_0000, 32'h0000_0000, 1'b1, KIND_REPLY, 1'b0},
      '{OP_CREATE,  4'd5,  32'h0000_0002, 32'h0000_0010, 1'b1, KIND_REPLY, 1'b0},
      '{OP_TICK,    4'd3,  32'h0000_0001, 32'h0000_0001, 1'b0, KIND_REPLY, 1'b0},
      '{OP_TICK,    4'd0,  32'h0000_0000, 32'h0000_0000, 1'b0, KIND_REPLY, 1'b0},
      '{OP_TICK,    4'd8,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, KIND_REPLY, 1'b0},
      '{OP_UPDATE,  4'd15, 32'h0000_0000, 32'h0000_0000, 1'b1, KIND_REPLY, 1'b0},
      '{OP_DESTROY, 4'd15, 32'h0000_0000, 32'h0000_0000, 1'b1, KIND_REPLY, 1'b0},
      '{OP_DESTROY, 4'd0,  32'h0000_0000, 32'h0000_0000, 1'b1, KIND_REPLY, 1'b0},
      '{OP_TICK,    4'd0,  32'h0000_0000, 32'h0000_0000, 1'b0, KIND_REPLY, 1'b0},
      '{OP_CREATE,  4'd10, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1, KIND_REPLY, 1'b0},
      '{OP_UPDATE,  4'd10, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, KIND_REPLY, 1'b0},
      '{OP_TICK,    4'd0,  32'h0000_0000, 32'h0000_0000, 1'b0, KIND_REPLY, 1'b0},
      '{OP_CREATE,  4'd3,  32'h5555_5555, 32'hAAAA_AAAA, 1'b1, KIND_REPLY, 1'b0},
      '{OP_CREATE,  4'd12, 32'hAAAA_AAAA, 32'h5555_5555, 1'b1, KIND_REPLY, 1'b0}
    };

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[r]) begin
      cmd_queue.push_back(plan[r]);
      cmds_in_flight++;
    end
    wait_drained();

    cfg_write(REG_TICK_SPAN, 32'd3);
    cfg_write(REG_MIN_SPAN, 32'd7);
    queue_random(50, 12, 4);
    wait_drained();

    cfg_write(REG_TICK_SPAN, 32'd0);
    cfg_write(REG_MIN_SPAN, 32'd5);
    queue_random(35, 2, 2);
    wait_drained();

    cfg_write(REG_TICK_SPAN, 32'hFFFF_FFFF);
    cfg_write(REG_MIN_SPAN, 32'hFFFF_FFFF);
    queue_random(35, 32'hFFFF_FFFF, 3);
    wait_drained();

    cfg_write(REG_SPARE_2, $urandom);
    cfg_write(REG_SPARE_3, $urandom);
    cfg_write(REG_TICK_SPAN, 32'd1);
    cfg_write(REG_MIN_SPAN, 32'd1);
    queue_random(40, 6, 2);
    hold_req++;
    wait_drained();

    if (errors == 0 && pending_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
